// ----- rtl/core/esd_pkg.sv -----
package esd_pkg;

  // Drive modes.
  localparam logic [1:0] MD_OFF = 2'd0;
  localparam logic [1:0] MD_FWD = 2'd1;
  localparam logic [1:0] MD_BWD = 2'd2;
  localparam logic [1:0] MD_DIR = 2'd3;

  // Request status codes.
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_RANGE    = 2'd1;
  localparam logic [1:0] STAT_MISMATCH = 2'd2;

  // Drive state codes as reported on the result.
  localparam logic [1:0] DS_OFF    = 2'd0;
  localparam logic [1:0] DS_BRAKE  = 2'd1;
  localparam logic [1:0] DS_FB     = 2'd2;
  localparam logic [1:0] DS_UNLOCK = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_NFE = 2'd0;
  localparam logic [1:0] REG_FF  = 2'd1;
  localparam logic [1:0] REG_NBE = 2'd2;
  localparam logic [1:0] REG_FB  = 2'd3;

  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_REQ  = 1'b1;

  localparam int ADDR_W   = 4;
  localparam int CFG_W    = 11;
  localparam int VAL_W    = 11;
  localparam int PULSE_W  = 12;
  localparam int HOLD_W   = 11;

  localparam int PULSE_NEUTRAL = 1500;
  localparam int HOLD_SHORT    = 100;
  localparam int HOLD_LONG     = 1500;
  localparam int BRAKE_PCT     = 20;
  localparam int PCT_FULL      = 100;
  localparam int FWD_MAX       = 1000;
  localparam int BWD_MAX       = 500;
  localparam int NEG_MIN       = -500;

  localparam logic signed [CFG_W-1:0] RST_NFE = -11'sd52;
  localparam logic signed [CFG_W-1:0] RST_FF  = -11'sd500;
  localparam logic signed [CFG_W-1:0] RST_NBE = 11'sd53;
  localparam logic signed [CFG_W-1:0] RST_FB  = 11'sd250;

  // Constant divisors of the linear maps, done as reciprocal multiplies.
  localparam int FWD_SPAN  = FWD_MAX - 1;
  localparam int BWD_SPAN  = BWD_MAX - 1;
  localparam int BRAKE_DIV = PCT_FULL / BRAKE_PCT;

  localparam int FWD_SHIFT   = 31;
  localparam int BWD_SHIFT   = 29;
  localparam int BRAKE_SHIFT = 16;

  localparam logic [21:0] FWD_RECIP =
    22'(((64'd1 << FWD_SHIFT) + 64'(FWD_SPAN) - 64'd1) / 64'(FWD_SPAN));
  localparam logic [20:0] BWD_RECIP =
    21'(((64'd1 << BWD_SHIFT) + 64'(BWD_SPAN) - 64'd1) / 64'(BWD_SPAN));
  localparam logic [13:0] BRAKE_RECIP =
    14'(((64'd1 << BRAKE_SHIFT) + 64'(BRAKE_DIV) - 64'd1) / 64'(BRAKE_DIV));

  typedef enum logic [3:0] {
    TS_OFF    = 4'b0001,
    TS_BRAKE  = 4'b0010,
    TS_FB     = 4'b0100,
    TS_UNLOCK = 4'b1000
  } thr_state_t;

  typedef struct packed {
    logic signed [CFG_W-1:0] nfe;
    logic signed [CFG_W-1:0] ff;
    logic signed [CFG_W-1:0] nbe;
    logic signed [CFG_W-1:0] fb;
  } cfg_t;

  typedef struct packed {
    logic               kind;
    logic [1:0]         mode;
    logic signed [15:0] value;
    logic               rep_given;
    logic signed [15:0] rep_value;
    logic               dm_given;
    logic [15:0]        dm_ms;
  } item_t;

  typedef struct packed {
    logic [PULSE_W-1:0]      pulse_width;
    logic                    battery_on;
    logic [1:0]              drive_state;
    logic [1:0]              active_mode;
    logic signed [VAL_W-1:0] active_value;
    logic [1:0]              status;
    logic [15:0]             deadman_setting;
  } result_t;

  typedef struct packed {
    logic signed [23:0]  fwd_prod;
    logic signed [23:0]  bwd_prod;
    logic [PULSE_W-1:0]  brake_pulse;
  } scale_t;

endpackage

// ----- rtl/core/esd_cfg.sv -----
module esd_cfg import esd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg,
  output cfg_t              cfg_next
);

  logic       wr;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[3:2];

  // The next value is visible to the scaling stage so that its products
  // follow a register write in the same cycle.
  always_comb begin
    cfg_next = cfg;
    if (rst) begin
      cfg_next.nfe = RST_NFE;
      cfg_next.ff  = RST_FF;
      cfg_next.nbe = RST_NBE;
      cfg_next.fb  = RST_FB;
    end else if (wr) begin
      unique case (idx)
        REG_NFE: cfg_next.nfe = pwdata[CFG_W-1:0];
        REG_FF:  cfg_next.ff  = pwdata[CFG_W-1:0];
        REG_NBE: cfg_next.nbe = pwdata[CFG_W-1:0];
        REG_FB:  cfg_next.fb  = pwdata[CFG_W-1:0];
        default: cfg_next = cfg;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    cfg <= cfg_next;
  end

  always_comb begin
    unique case (idx)
      REG_NFE: prdata = {{(32-CFG_W){cfg.nfe[CFG_W-1]}}, cfg.nfe};
      REG_FF:  prdata = {{(32-CFG_W){cfg.ff[CFG_W-1]}}, cfg.ff};
      REG_NBE: prdata = {{(32-CFG_W){cfg.nbe[CFG_W-1]}}, cfg.nbe};
      REG_FB:  prdata = {{(32-CFG_W){cfg.fb[CFG_W-1]}}, cfg.fb};
      default: prdata = '0;
    endcase
  end

endmodule

// ----- rtl/core/esd_scale.sv -----
module esd_scale import esd_pkg::*; (
  input  logic                    clk,
  input  cfg_t                    cfg_next,
  input  logic signed [VAL_W-1:0] seed,
  output scale_t                  scale
);

  logic signed [11:0] fwd_span_d;
  logic signed [11:0] bwd_span_d;
  logic signed [11:0] seed_m1;
  logic [VAL_W-1:0]   seed_abs;
  logic signed [11:0] seed_abs_m1;
  logic signed [11:0] brake_d;
  logic [10:0]        brake_mag;
  logic [24:0]        brake_full;
  logic [8:0]         brake_q;
  logic signed [11:0] brake_q_s;
  logic signed [11:0] brake_off;

  assign fwd_span_d  = 12'(cfg_next.ff) - 12'(cfg_next.nfe);
  assign bwd_span_d  = 12'(cfg_next.fb) - 12'(cfg_next.nbe);
  assign seed_m1     = 12'(seed) - 12'sd1;
  assign seed_abs    = seed[VAL_W-1] ? VAL_W'(-seed) : seed;
  assign seed_abs_m1 = $signed({1'b0, seed_abs}) - 12'sd1;

  // Braking point: twenty percent of the way into the backward range.
  assign brake_d    = bwd_span_d;
  assign brake_mag  = brake_d[11] ? 11'(-brake_d) : brake_d[10:0];
  assign brake_full = brake_mag * BRAKE_RECIP;
  assign brake_q    = brake_full[BRAKE_SHIFT+8:BRAKE_SHIFT];
  assign brake_q_s  = brake_d[11] ? -$signed({3'b000, brake_q}) : $signed({3'b000, brake_q});
  assign brake_off  = brake_q_s + 12'(cfg_next.nbe);

  // Products are kept in step with the requested value, so the tick path
  // only has the constant divide left.
  always_ff @(posedge clk) begin
    scale.fwd_prod    <= fwd_span_d * seed_m1;
    scale.bwd_prod    <= bwd_span_d * seed_abs_m1;
    scale.brake_pulse <= PULSE_W'(PULSE_NEUTRAL) + brake_off[PULSE_W-1:0];
  end

endmodule

// ----- rtl/core/esd_step.sv -----
module esd_step import esd_pkg::*; #(
  parameter int DEADMAN_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    fire,
  input  item_t                   item,
  input  cfg_t                    cfg,
  input  scale_t                  scale,
  output result_t                 result_next,
  output logic signed [VAL_W-1:0] seed
);

  localparam logic signed [15:0] LO_NEG = 16'(NEG_MIN);
  localparam logic signed [15:0] HI_FWD = 16'(FWD_MAX);
  localparam logic signed [15:0] HI_BWD = 16'(BWD_MAX);

  logic [DEADMAN_BITS:0]   dm_count, dm_count_next;
  logic [DEADMAN_BITS-1:0] dm_time, dm_time_next;
  logic [HOLD_W-1:0]       hold, hold_next;
  logic [1:0]              req_mode, req_mode_next;
  logic [1:0]              app_mode, app_mode_next;
  logic signed [VAL_W-1:0] req_val, req_val_next;
  logic signed [VAL_W-1:0] app_val, app_val_next;
  thr_state_t              thr, thr_next;
  logic [PULSE_W-1:0]      pulse, pulse_next;
  logic                    bat, bat_next;

  logic [DEADMAN_BITS+15:0] dm_ext;
  logic [DEADMAN_BITS-1:0]  dm_in;
  logic [DEADMAN_BITS-1:0]  dm_sel;
  logic [DEADMAN_BITS+15:0] dm_set_ext;
  logic                     mismatch, in_range, req_ok;
  logic [1:0]               req_status, status_next;
  logic                     apply, changed;
  logic signed [13:0]       lin_d;
  logic signed [13:0]       cur;
  logic                     pos_neg, pos_pos;

  logic                     fwd_neg, bwd_neg;
  logic [22:0]              fwd_mag, bwd_mag;
  logic [44:0]              fwd_full;
  logic [43:0]              bwd_full;
  logic [11:0]              fwd_q, bwd_q;
  logic signed [12:0]       fwd_q_s, bwd_q_s;
  logic signed [13:0]       fwd_lin, bwd_lin;
  logic [1:0]               ds_code;

  assign dm_ext = {{DEADMAN_BITS{1'b0}}, item.dm_ms};
  assign dm_in  = dm_ext[DEADMAN_BITS-1:0];

  // Request checks.
  assign mismatch = item.rep_given && (item.value != item.rep_value);
  always_comb begin
    unique case (item.mode)
      MD_DIR:  in_range = (item.value >= LO_NEG) && (item.value <= HI_BWD);
      MD_FWD:  in_range = (item.value >= LO_NEG) && (item.value <= HI_FWD);
      MD_BWD:  in_range = (item.value >= 16'sd0) && (item.value <= HI_BWD);
      default: in_range = 1'b1;
    endcase
  end
  assign req_ok = (item.mode == MD_OFF) || (!mismatch && in_range);
  assign req_status = (item.mode == MD_OFF) ? STAT_OK :
                      mismatch ? STAT_MISMATCH :
                      !in_range ? STAT_RANGE : STAT_OK;

  assign seed = (fire && item.kind == KIND_REQ && item.mode != MD_OFF && req_ok) ?
                item.value[VAL_W-1:0] : req_val;

  // Linear maps with truncation toward zero.
  assign fwd_neg  = scale.fwd_prod[23];
  assign fwd_mag  = fwd_neg ? 23'(-scale.fwd_prod) : scale.fwd_prod[22:0];
  assign fwd_full = fwd_mag * FWD_RECIP;
  assign fwd_q    = fwd_full[FWD_SHIFT+11:FWD_SHIFT];
  assign fwd_q_s  = fwd_neg ? -$signed({1'b0, fwd_q}) : $signed({1'b0, fwd_q});
  assign fwd_lin  = 14'(fwd_q_s) + 14'(cfg.nfe);

  assign bwd_neg  = scale.bwd_prod[23];
  assign bwd_mag  = bwd_neg ? 23'(-scale.bwd_prod) : scale.bwd_prod[22:0];
  assign bwd_full = bwd_mag * BWD_RECIP;
  assign bwd_q    = bwd_full[BWD_SHIFT+11:BWD_SHIFT];
  assign bwd_q_s  = bwd_neg ? -$signed({1'b0, bwd_q}) : $signed({1'b0, bwd_q});
  assign bwd_lin  = 14'(bwd_q_s) + 14'(cfg.nbe);

  always_comb begin
    dm_count_next = dm_count;
    dm_time_next  = dm_time;
    hold_next     = hold;
    req_mode_next = req_mode;
    app_mode_next = app_mode;
    req_val_next  = req_val;
    app_val_next  = app_val;
    thr_next      = thr;
    pulse_next    = pulse;
    bat_next      = bat;
    status_next   = STAT_OK;
    dm_sel        = dm_time;
    apply         = 1'b0;
    changed       = 1'b0;
    lin_d         = '0;
    cur           = '0;
    pos_neg       = 1'b0;
    pos_pos       = 1'b0;
    if (fire) begin
      if (item.kind == KIND_REQ) begin
        status_next = req_status;
        if (req_ok) begin
          req_mode_next = item.mode;
          if (item.mode != MD_OFF) begin
            req_val_next = item.value[VAL_W-1:0];
          end
          dm_sel       = item.dm_given ? dm_in : dm_time;
          dm_time_next = dm_sel;
          if (dm_sel != '0) begin
            dm_count_next = {1'b0, dm_sel} + (DEADMAN_BITS+1)'(1);
          end
        end
      end else begin
        // Dead-man timer: an expired timer keeps forcing the value to zero.
        if (dm_count > (DEADMAN_BITS+1)'(1)) begin
          dm_count_next = dm_count - (DEADMAN_BITS+1)'(1);
        end else if (dm_count == (DEADMAN_BITS+1)'(1)) begin
          req_val_next = '0;
        end

        if (hold != '0) begin
          hold_next = hold - HOLD_W'(1);
        end else begin
          if (req_mode == MD_OFF) begin
            if (app_mode != MD_OFF) begin
              pulse_next    = PULSE_W'(PULSE_NEUTRAL);
              bat_next      = 1'b0;
              app_mode_next = MD_OFF;
            end
          end else if (req_mode != app_mode) begin
            changed = 1'b1;
            if (app_mode == MD_OFF) begin
              // Power up into neutral; backward needs the long arming hold.
              pulse_next    = PULSE_W'(PULSE_NEUTRAL);
              bat_next      = 1'b1;
              app_mode_next = MD_FWD;
              hold_next     = (req_mode == MD_BWD) ? HOLD_W'(HOLD_LONG) : HOLD_W'(HOLD_SHORT);
            end else if (req_mode == MD_BWD) begin
              if (thr == TS_BRAKE) begin
                pulse_next = scale.brake_pulse;
                hold_next  = HOLD_W'(HOLD_SHORT);
              end else if (thr == TS_UNLOCK) begin
                pulse_next = PULSE_W'(PULSE_NEUTRAL);
                hold_next  = HOLD_W'(HOLD_SHORT);
              end else begin
                app_mode_next = MD_BWD;
                apply         = 1'b1;
              end
            end else begin
              app_mode_next = req_mode;
              apply         = 1'b1;
            end
          end else begin
            apply = 1'b1;
          end

          if (apply && (changed || req_val_next != app_val)) begin
            if (app_mode_next == MD_DIR) begin
              lin_d = 14'(req_val_next);
            end else if (app_mode_next == MD_FWD) begin
              if (req_val_next > 0) begin
                lin_d = fwd_lin;
              end else if (req_val_next < 0) begin
                if (thr == TS_FB) begin
                  req_val_next = '0;
                end else begin
                  lin_d = bwd_lin;
                end
              end
            end else begin
              if (req_val_next <= 0) begin
                req_val_next = '0;
              end else begin
                lin_d = bwd_lin;
              end
            end
            pulse_next   = PULSE_W'(PULSE_NEUTRAL) + lin_d[PULSE_W-1:0];
            app_val_next = req_val_next;
          end
        end

        // Throttle position tracking from the pulse just set.
        if (!bat_next) begin
          thr_next = TS_OFF;
        end else begin
          cur     = $signed({2'b00, pulse_next}) - 14'(PULSE_NEUTRAL);
          pos_neg = cur < cfg.nfe;
          pos_pos = !pos_neg && (cur > cfg.nbe);
          unique case (thr)
            TS_BRAKE: begin
              if (pos_pos) thr_next = TS_UNLOCK;
            end
            TS_UNLOCK: begin
              if (pos_neg) thr_next = TS_BRAKE;
              else if (!pos_pos) thr_next = TS_FB;
            end
            TS_FB: begin
              if (pos_neg) thr_next = TS_BRAKE;
            end
            TS_OFF:  thr_next = TS_BRAKE;
            default: thr_next = TS_BRAKE;
          endcase
        end
      end
    end
  end

  always_comb begin
    unique case (thr_next)
      TS_OFF:    ds_code = DS_OFF;
      TS_BRAKE:  ds_code = DS_BRAKE;
      TS_FB:     ds_code = DS_FB;
      TS_UNLOCK: ds_code = DS_UNLOCK;
      default:   ds_code = DS_OFF;
    endcase
  end

  assign dm_set_ext = {16'b0, dm_time_next};

  always_comb begin
    result_next.pulse_width     = pulse_next;
    result_next.battery_on      = bat_next;
    result_next.drive_state     = ds_code;
    result_next.active_mode     = app_mode_next;
    result_next.active_value    = app_val_next;
    result_next.status          = status_next;
    result_next.deadman_setting = dm_set_ext[15:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dm_count <= '0;
      dm_time  <= '0;
      hold     <= '0;
      req_mode <= MD_OFF;
      app_mode <= MD_OFF;
      req_val  <= '0;
      app_val  <= '0;
      thr      <= TS_OFF;
      pulse    <= '0;
      bat      <= 1'b0;
    end else if (fire) begin
      dm_count <= dm_count_next;
      dm_time  <= dm_time_next;
      hold     <= hold_next;
      req_mode <= req_mode_next;
      app_mode <= app_mode_next;
      req_val  <= req_val_next;
      app_val  <= app_val_next;
      thr      <= thr_next;
      pulse    <= pulse_next;
      bat      <= bat_next;
    end
  end

  a_bat_follows_mode: assert property (@(posedge clk) disable iff (rst)
    (app_mode == MD_OFF) == !bat)
    else $error("battery enable out of step with applied mode");

  a_thr_off_without_bat: assert property (@(posedge clk) disable iff (rst)
    !bat |-> (thr == TS_OFF))
    else $error("throttle tracking active with battery off");

  a_reject_keeps_request: assert property (@(posedge clk) disable iff (rst)
    (fire && item.kind == KIND_REQ && req_status != STAT_OK) |=>
      (req_mode == $past(req_mode)) && (req_val == $past(req_val)))
    else $error("rejected request changed the requested drive");

endmodule

// ----- rtl/core/esc_drive_sequencer.sv -----
// Channel  | Dir | Beat contents
// s_*      | in  | tick (tuser = 0) or drive request (tuser = 1) with its fields
// m_*      | out | one drive snapshot per input beat
// APB      | in  | calibration writes and reads, four registers at 4*i
//
// Each beat passes through the input register and then the result register,
// and one beat is taken every cycle while the result is not stalled.
// The state update between those registers is combinational.
// Reset clears all drive state and loads the calibration defaults.
// A stalled result holds the input register; that is the only source of backpressure.
module esc_drive_sequencer import esd_pkg::*; #(
  parameter int DEADMAN_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  // mode[1:0], value[17:2], repeat_given[18], repeat_value[34:19],
  // deadman_given[35], deadman_ms[51:36], zero pad[55:52]
  input  logic [55:0]       s_tdata,
  // kind[0]
  input  logic              s_tuser,
  output logic              m_tvalid,
  input  logic              m_tready,
  // pulse_width[11:0], battery_on[12], drive_state[14:13], active_mode[16:15],
  // active_value[27:17], status[29:28], deadman_setting[45:30], zero pad[47:46]
  output logic [47:0]       m_tdata,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  item_t                   in_item;
  logic                    in_valid;
  result_t                 out_res;
  logic                    out_valid;
  logic                    advance;
  logic                    fire;
  cfg_t                    cfg;
  cfg_t                    cfg_next;
  scale_t                  scale;
  result_t                 result_next;
  logic signed [VAL_W-1:0] seed;

  assign advance  = !out_valid || m_tready;
  assign fire     = in_valid && advance;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item.kind      <= s_tuser;
      in_item.mode      <= s_tdata[1:0];
      in_item.value     <= s_tdata[17:2];
      in_item.rep_given <= s_tdata[18];
      in_item.rep_value <= s_tdata[34:19];
      in_item.dm_given  <= s_tdata[35];
      in_item.dm_ms     <= s_tdata[51:36];
    end
  end

  esd_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .cfg      (cfg),
    .cfg_next (cfg_next)
  );

  esd_scale u_scale (
    .clk      (clk),
    .cfg_next (cfg_next),
    .seed     (seed),
    .scale    (scale)
  );

  esd_step #(
    .DEADMAN_BITS (DEADMAN_BITS)
  ) u_step (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .item        (in_item),
    .cfg         (cfg),
    .scale       (scale),
    .result_next (result_next),
    .seed        (seed)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res <= result_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {2'b00, out_res.deadman_setting, out_res.status, out_res.active_value,
                     out_res.active_mode, out_res.drive_state, out_res.battery_on,
                     out_res.pulse_width};

  a_fire_gives_beat: assert property (@(posedge clk) disable iff (rst)
    fire |=> m_tvalid)
    else $error("processed beat did not reach the output register");

  a_empty_out_takes_in: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled while the output register is empty");

endmodule

// ----- sim/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import esd_pkg::*;

  localparam int PHASE_ITEMS = 380;
  localparam int STALL_LIMIT = 5000;
  localparam int MAX_REPORTS = 40;

  // Receiver stall patterns.
  localparam int RX_FREE     = 0;
  localparam int RX_RANDOM   = 1;
  localparam int RX_PERIODIC = 2;
  localparam int RX_BURSTY   = 3;

  class drive_scoreboard;
    int nfe, ffw, nbe, fbw;
    logic [16:0] dm_count;
    logic [15:0] dm_time;
    int hold;
    logic [1:0] req_mode, app_mode, thr;
    int req_val, app_val;
    logic [11:0] pulse;
    bit bat;
    result_t pending[$];
    int errors, checked, n_ticks, n_ok, n_range, n_mismatch, n_expired;
    bit seen_ds[4];

    function new();
      nfe = RST_NFE;
      ffw = RST_FF;
      nbe = RST_NBE;
      fbw = RST_FB;
      dm_count = '0;
      dm_time = '0;
      hold = 0;
      req_mode = MD_OFF;
      app_mode = MD_OFF;
      thr = DS_OFF;
      req_val = 0;
      app_val = 0;
      pulse = '0;
      bat = 1'b0;
    endfunction

    function void set_cal(logic [1:0] idx, int v);
      logic signed [CFG_W-1:0] t;
      t = v[CFG_W-1:0];
      case (idx)
        REG_NFE: nfe = t;
        REG_FF:  ffw = t;
        REG_NBE: nbe = t;
        default: fbw = t;
      endcase
    endfunction

    function logic [CFG_W-1:0] cal_of(logic [1:0] idx);
      case (idx)
        REG_NFE: return nfe[CFG_W-1:0];
        REG_FF:  return ffw[CFG_W-1:0];
        REG_NBE: return nbe[CFG_W-1:0];
        default: return fbw[CFG_W-1:0];
      endcase
    endfunction

    // Linear map between two calibration points; int division truncates toward zero.
    function int ramp(int x, int xa, int xb, int ya, int yb);
      return ((yb - ya) * (x - xa)) / (xb - xa) + ya;
    endfunction

    function logic [11:0] pulse_at(int d);
      return 12'(PULSE_NEUTRAL + d);
    endfunction

    function void step_tick();
      bit apply, changed;
      int d, v, cur, pos;
      apply = 1'b0;
      changed = 1'b0;
      n_ticks++;
      if (dm_count > 1) begin
        dm_count--;
      end else if (dm_count == 1) begin
        req_val = 0;
        n_expired++;
      end

      if (hold > 0) begin
        hold--;
      end else begin
        if (req_mode == MD_OFF) begin
          if (app_mode != MD_OFF) begin
            pulse = PULSE_NEUTRAL;
            bat = 1'b0;
            app_mode = MD_OFF;
          end
        end else if (req_mode != app_mode) begin
          changed = 1'b1;
          if (app_mode == MD_OFF) begin
            // Power up in forward at neutral and let the controller arm.
            pulse = PULSE_NEUTRAL;
            bat = 1'b1;
            app_mode = MD_FWD;
            hold = (req_mode == MD_BWD) ? HOLD_LONG : HOLD_SHORT;
          end else if (req_mode == MD_BWD) begin
            if (thr == DS_BRAKE) begin
              pulse = pulse_at(ramp(BRAKE_PCT, 0, PCT_FULL, nbe, fbw));
              hold = HOLD_SHORT;
            end else if (thr == DS_UNLOCK) begin
              pulse = PULSE_NEUTRAL;
              hold = HOLD_SHORT;
            end else begin
              app_mode = MD_BWD;
              apply = 1'b1;
            end
          end else begin
            app_mode = req_mode;
            apply = 1'b1;
          end
        end else begin
          apply = 1'b1;
        end

        if (apply && (changed || req_val != app_val)) begin
          d = 0;
          v = req_val;
          if (app_mode == MD_DIR) begin
            d = v;
          end else if (app_mode == MD_FWD) begin
            if (v > 0) begin
              d = ramp(v, 1, FWD_MAX, nfe, ffw);
            end else if (v < 0) begin
              if (thr == DS_FB) req_val = 0;
              else d = ramp(-v, 1, BWD_MAX, nbe, fbw);
            end
          end else begin
            if (v <= 0) req_val = 0;
            else d = ramp(v, 1, BWD_MAX, nbe, fbw);
          end
          pulse = pulse_at(d);
          app_val = req_val;
        end
      end

      if (!bat) begin
        thr = DS_OFF;
      end else begin
        cur = int'(pulse) - PULSE_NEUTRAL;
        pos = 0;
        if (cur < nfe) pos = -1;
        else if (cur > nbe) pos = 1;
        case (thr)
          DS_BRAKE: if (pos == 1) thr = DS_UNLOCK;
          DS_UNLOCK: begin
            if (pos == -1) thr = DS_BRAKE;
            else if (pos == 0) thr = DS_FB;
          end
          DS_FB: if (pos == -1) thr = DS_BRAKE;
          default: thr = DS_BRAKE;
        endcase
      end
    endfunction

    function logic [1:0] take_request(item_t it);
      int lo, hi;
      if (it.mode == MD_OFF) begin
        req_mode = MD_OFF;
      end else begin
        if (it.rep_given && it.value != it.rep_value) return STAT_MISMATCH;
        case (it.mode)
          MD_DIR: begin lo = NEG_MIN; hi = BWD_MAX; end
          MD_FWD: begin lo = NEG_MIN; hi = FWD_MAX; end
          default: begin lo = 0; hi = BWD_MAX; end
        endcase
        if (int'(it.value) < lo || int'(it.value) > hi) return STAT_RANGE;
        req_mode = it.mode;
        req_val = it.value;
      end
      if (it.dm_given) dm_time = it.dm_ms;
      if (dm_time != 0) dm_count = {1'b0, dm_time} + 17'd1;
      return STAT_OK;
    endfunction

    function void note_item(item_t it);
      result_t want;
      logic [1:0] st;
      st = STAT_OK;
      if (it.kind == KIND_REQ) begin
        st = take_request(it);
        case (st)
          STAT_OK:    n_ok++;
          STAT_RANGE: n_range++;
          default:    n_mismatch++;
        endcase
      end else begin
        step_tick();
      end
      seen_ds[thr] = 1'b1;
      want.pulse_width = pulse;
      want.battery_on = bat;
      want.drive_state = thr;
      want.active_mode = app_mode;
      want.active_value = app_val[VAL_W-1:0];
      want.status = st;
      want.deadman_setting = dm_time;
      pending.push_back(want);
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (errors <= MAX_REPORTS) $display("ERROR %0t: %s", $time, msg);
    endtask

    task check_result(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        report_mismatch("result beat with nothing outstanding");
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.pulse_width !== want.pulse_width)
        report_mismatch($sformatf("beat %0d pulse_width %0d, want %0d",
                                  checked, got.pulse_width, want.pulse_width));
      if (got.battery_on !== want.battery_on)
        report_mismatch($sformatf("beat %0d battery_on %0d, want %0d",
                                  checked, got.battery_on, want.battery_on));
      if (got.drive_state !== want.drive_state)
        report_mismatch($sformatf("beat %0d drive_state %0d, want %0d",
                                  checked, got.drive_state, want.drive_state));
      if (got.active_mode !== want.active_mode)
        report_mismatch($sformatf("beat %0d active_mode %0d, want %0d",
                                  checked, got.active_mode, want.active_mode));
      if (got.active_value !== want.active_value)
        report_mismatch($sformatf("beat %0d active_value %0d, want %0d",
                                  checked, got.active_value, want.active_value));
      if (got.status !== want.status)
        report_mismatch($sformatf("beat %0d status %0d, want %0d",
                                  checked, got.status, want.status));
      if (got.deadman_setting !== want.deadman_setting)
        report_mismatch($sformatf("beat %0d deadman_setting %0d, want %0d",
                                  checked, got.deadman_setting, want.deadman_setting));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [55:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  drive_scoreboard sb;
  result_t out_beat;
  int n_items = 0;
  int burst_left = 0;
  int quiet_cycles = 0;
  int rx_cycle = 0;
  int rx_pattern = RX_FREE;
  int rx_hold = 0;
  bit long_done = 1'b0;

  esc_drive_sequencer dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Receiver backpressure: the stall pattern is redrawn at random periodically.
  always @(negedge clk) begin
    rx_cycle++;
    if (rx_cycle % 256 == 0) rx_pattern = $urandom_range(RX_FREE, RX_BURSTY);
    case (rx_pattern)
      RX_FREE:     m_tready <= 1'b1;
      RX_RANDOM:   m_tready <= ($urandom_range(0, 3) != 0);
      RX_PERIODIC: m_tready <= (rx_cycle % 3 != 0);
      default: begin
        if (rx_hold > 0) begin
          rx_hold--;
          m_tready <= 1'b0;
        end else begin
          m_tready <= 1'b1;
          if ($urandom_range(0, 15) == 0) rx_hold = $urandom_range(1, 20);
        end
      end
    endcase
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        out_beat.pulse_width = m_tdata[11:0];
        out_beat.battery_on = m_tdata[12];
        out_beat.drive_state = m_tdata[14:13];
        out_beat.active_mode = m_tdata[16:15];
        out_beat.active_value = m_tdata[27:17];
        out_beat.status = m_tdata[29:28];
        out_beat.deadman_setting = m_tdata[45:30];
        sb.check_result(out_beat);
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("Watchdog: no beat moved for %0d cycles", STALL_LIMIT);
          $display("Regression FAIL");
          $finish;
        end
      end
    end
  end

  function automatic item_t mk_req(logic [1:0] md, int v, bit rg, int rv, bit dg, int ms);
    item_t it;
    it.kind = KIND_REQ;
    it.mode = md;
    it.value = 16'(v);
    it.rep_given = rg;
    it.rep_value = 16'(rv);
    it.dm_given = dg;
    it.dm_ms = 16'(ms);
    return it;
  endfunction

  // Tick fields other than kind are don't-care, so they carry random bits.
  function automatic item_t tick_item();
    item_t it;
    it = mk_req(2'($urandom), $urandom, 1'($urandom), $urandom, 1'($urandom), $urandom);
    it.kind = KIND_TICK;
    return it;
  endfunction

  function automatic int pick_value(logic [1:0] md);
    int lo, hi, r;
    case (md)
      MD_FWD: begin lo = NEG_MIN; hi = FWD_MAX; end
      MD_BWD: begin lo = 0; hi = BWD_MAX; end
      default: begin lo = NEG_MIN; hi = BWD_MAX; end
    endcase
    r = $urandom_range(0, 9);
    if (r == 0) return lo;
    if (r == 1) return hi;
    if (r == 2) return 0;
    return lo + int'($urandom_range(hi - lo));
  endfunction

  function automatic item_t drive_req(logic [1:0] md);
    int v;
    v = pick_value(md);
    return mk_req(md, v, 1'($urandom), v, ($urandom_range(0, 7) == 0),
                  $urandom_range(0, 40));
  endfunction

  function automatic item_t noise_req();
    item_t it;
    it = mk_req(2'($urandom), $urandom, 1'($urandom), $urandom, 1'($urandom), $urandom);
    if ($urandom_range(0, 1) != 0) it.value = 16'(int'($urandom_range(1700)) - 600);
    if ($urandom_range(0, 1) != 0) it.rep_value = it.value;
    return it;
  endfunction

  task automatic push_item(input item_t it);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      if ($urandom_range(0, 3) != 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata <= {4'b0, it.dm_ms, it.dm_given, it.rep_value, it.rep_given, it.value, it.mode};
    s_tuser <= it.kind;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_item(it);
    n_items++;
    burst_left--;
    @(negedge clk);
  endtask

  task automatic run_ticks(input int n);
    repeat (n) push_item(tick_item());
  endtask

  task automatic quiesce();
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic cal_set(input logic [1:0] idx, input int v);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= 32'(v);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_cal(idx, v);
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[CFG_W-1:0] !== sb.cal_of(idx))
      sb.report_mismatch($sformatf("register %0d reads %0d, want %0d",
                                   idx, prdata[CFG_W-1:0], sb.cal_of(idx)));
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apply_cal(input int a, input int b, input int c, input int d);
    cal_set(REG_NFE, a);
    cal_set(REG_FF, b);
    cal_set(REG_NBE, c);
    cal_set(REG_FB, d);
  endtask

  function automatic int any_cal();
    return int'($urandom_range(2000)) - 1000;
  endfunction

  task automatic run_scenario();
    int r, ms;
    item_t it;
    r = $urandom_range(0, 99);
    if (r < 35) begin
      push_item(drive_req(2'($urandom_range(MD_FWD, MD_DIR))));
      run_ticks($urandom_range(0, 8));
    end else if (r < 55) begin
      push_item(drive_req(2'($urandom_range(MD_FWD, MD_DIR))));
      run_ticks($urandom_range(96, 106));
    end else if (r < 63) begin
      // Forward first, then through brake and unlock into backward.
      push_item(drive_req(MD_FWD));
      run_ticks($urandom_range(100, 106));
      push_item(drive_req(MD_BWD));
      run_ticks($urandom_range(195, 215));
      repeat (3) begin
        push_item(drive_req(MD_BWD));
        run_ticks($urandom_range(0, 5));
      end
    end else if (r < 73) begin
      ms = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      it = drive_req(2'($urandom_range(MD_FWD, MD_DIR)));
      it.dm_given = 1'b1;
      it.dm_ms = 16'(ms);
      push_item(it);
      run_ticks(ms + $urandom_range(0, 20));
    end else if (r < 80) begin
      push_item(mk_req(MD_OFF, $urandom, 1'($urandom), $urandom,
                       ($urandom_range(0, 3) == 0), $urandom_range(0, 30)));
      run_ticks($urandom_range(0, 4));
    end else if (r < 99 || long_done) begin
      push_item(noise_req());
      run_ticks($urandom_range(0, 3));
    end else begin
      // Straight from off into backward takes the long arming hold.
      long_done = 1'b1;
      push_item(mk_req(MD_OFF, 0, 1'b0, 0, 1'b0, 0));
      run_ticks(110);
      push_item(drive_req(MD_BWD));
      run_ticks($urandom_range(1500, 1520));
    end
  endtask

  initial begin
    int goal;
    sb = new();
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    push_item(tick_item());
    push_item(mk_req(MD_FWD, 1001, 1'b0, 0, 1'b1, 77));
    push_item(mk_req(MD_DIR, -501, 1'b0, 0, 1'b0, 0));
    push_item(mk_req(MD_DIR, 501, 1'b0, 0, 1'b0, 0));
    push_item(mk_req(MD_BWD, -1, 1'b0, 0, 1'b0, 0));
    push_item(mk_req(MD_FWD, 10, 1'b1, 11, 1'b1, 5));
    push_item(mk_req(MD_BWD, -32768, 1'b1, -32768, 1'b0, 0));
    push_item(mk_req(MD_DIR, 32767, 1'b1, -32768, 1'b0, 0));
    // Off ignores value and repeat; then a zero time leaves the count running.
    push_item(mk_req(MD_OFF, 32767, 1'b1, 0, 1'b1, 65535));
    push_item(mk_req(MD_OFF, 0, 1'b0, 0, 1'b1, 0));
    push_item(mk_req(MD_FWD, 1000, 1'b1, 1000, 1'b1, 3));
    run_ticks(4);
    push_item(mk_req(MD_FWD, -500, 1'b0, 0, 1'b0, 0));
    push_item(mk_req(MD_DIR, 500, 1'b1, 500, 1'b0, 0));
    push_item(mk_req(MD_DIR, -500, 1'b0, 0, 1'b0, 0));
    push_item(mk_req(MD_BWD, 500, 1'b0, 0, 1'b0, 0));
    push_item(mk_req(MD_BWD, 0, 1'b0, 0, 1'b0, 0));
    push_item(mk_req(MD_FWD, 1, 1'b0, 0, 1'b0, 0));
    run_ticks(2);

    for (int p = 0; p < 5; p++) begin
      quiesce();
      case (p)
        0: apply_cal(any_cal(), any_cal(), any_cal(), any_cal());
        1: apply_cal(1000, -1000, -1000, 1000);
        2: apply_cal(-1000, 1000, 1000, -1000);
        3: apply_cal(any_cal(), any_cal(), any_cal(), any_cal());
        default: apply_cal(RST_NFE, RST_FF, RST_NBE, RST_FB);
      endcase
      goal = n_items + PHASE_ITEMS;
      while (n_items < goal) run_scenario();
    end
    quiesce();

    $display("Sent %0d beats (%0d ticks), checked %0d results over 6 calibrations",
             n_items, sb.n_ticks, sb.checked);
    $display("Requests ok/range/mismatch %0d/%0d/%0d, dead-man expiry ticks %0d, %0s%0s%0s%0s",
             sb.n_ok, sb.n_range, sb.n_mismatch, sb.n_expired,
             sb.seen_ds[DS_OFF] ? "off " : "", sb.seen_ds[DS_BRAKE] ? "brake " : "",
             sb.seen_ds[DS_FB] ? "fwd-bwd " : "", sb.seen_ds[DS_UNLOCK] ? "unlock" : "");
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
